// File: rtl/core/bsfn_pkg.sv
// Package for the bit set with find-next: store geometry, operation codes
// and the lowest-set-bit helper.
// No dependencies; used by the top level and the testbench.
package bsfn_pkg;

	// Store geometry
	localparam int SET_WORDS = 64;
	localparam int WORD_BITS = 64;
	localparam int WORD_AW   = (SET_WORDS > 1) ? $clog2(SET_WORDS) : 1;
	localparam logic [32:0] STORE_BITS = 33'(SET_WORDS) * 33'(WORD_BITS);
	localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(SET_WORDS - 1);
	localparam logic [WORD_BITS-1:0] FULL_WORD = {WORD_BITS{1'b1}};

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [WORD_AW-1:0]   word_idx_t;

	// Operation codes
	typedef enum logic [2:0] {
		OP_SET       = 3'd0,
		OP_CLEAR     = 3'd1,
		OP_TEST      = 3'd2,
		OP_FIND_NEXT = 3'd3,
		OP_SET_RANGE = 3'd4,
		OP_CLEAR_ALL = 3'd5,
		OP_SET_ALL   = 3'd6,
		OP_INVERT    = 3'd7
	} op_t;

	// Position of the lowest one in a word, by halving in six steps
	function automatic logic [5:0] lowest_one(input word_t w);
		word_t      v;
		word_t      mask;
		logic [5:0] n;
		v = w;
		n = '0;
		for (int k = 5; k >= 0; k--) begin
			mask = (word_t'(1) << (1 << k)) - word_t'(1);
			if ((v & mask) == '0) begin
				n[k] = 1'b1;
				v    = v >> (1 << k);
			end
		end
		return n;
	endfunction

endpackage

// File: rtl/core/bsfn_req_if.sv
// Request channel of the bit set: valid/ready handshake with the operation word.
// Depends on nothing.
interface bsfn_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] element;
	logic [31:0] range_end;

	modport source (output valid, output operation, output element, output range_end,
		input ready);
	modport sink (input valid, input operation, input element, input range_end,
		output ready);
endinterface

// File: rtl/core/bsfn_rsp_if.sv
// Response channel of the bit set: valid/ready handshake with the result word.
// Depends on nothing.
interface bsfn_rsp_if;
	logic        valid;
	logic        ready;
	logic        flag;
	logic [31:0] found_element;
	logic        out_of_range;

	modport source (output valid, output flag, output found_element, output out_of_range,
		input ready);
	modport sink (input valid, input flag, input found_element, input out_of_range,
		output ready);
endinterface

// File: rtl/core/bitset_with_find_next.sv
// Top level of the bit set with find-next: word store, sequencer and response register.
// Depends on bsfn_pkg, bsfn_req_if and bsfn_rsp_if.

// The set lives in a single-port memory of 64-bit words with a registered read,
// plus a default bit for every element beyond the store. Each word in the store
// has a valid flop; a word not yet written since the last clear-all or set-all
// reads as the default bit, and invert toggles a mask applied on every read and
// write, so the three whole-set operations finish at acceptance. Set and clear
// do one read-modify-write, test one read. Find-next and set-range walk the
// store one word at a time (read, then evaluate and, for set-range, write back);
// find-next visits at most every word from the start word to the last one. An
// operation that resolves without touching the store (element beyond the store,
// empty range) goes from acceptance straight to the done state. One word is in
// flight at a time: the sequencer only returns to idle after the write back, so
// a read never overlaps a write to the same word. A finished result is held in
// the response register while the next word is accepted.
module bitset_with_find_next (
	input  logic        clk,
	input  logic        arst_n,
	bsfn_req_if.sink    req,
	bsfn_rsp_if.source  rsp
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_EVAL = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [bsfn_pkg::SET_WORDS-1:0] valid_q;
	logic                        default_q;
	logic                        inv_q;
	logic                        rsp_vld_q;

	bsfn_pkg::word_t             mem [bsfn_pkg::SET_WORDS];
	bsfn_pkg::word_t             rd_data_s1;
	logic                        rd_vld_s1;

	bsfn_pkg::op_t               op_q;
	logic [5:0]                  lo_q;
	logic [5:0]                  top_lo_q;
	bsfn_pkg::word_idx_t         word_q;
	bsfn_pkg::word_idx_t         first_w_q;
	bsfn_pkg::word_idx_t         end_w_q;
	logic                        res_flag_q;
	logic [31:0]                 res_found_q;
	logic                        res_oor_q;
	logic                        rsp_flag_q;
	logic [31:0]                 rsp_found_q;
	logic                        rsp_oor_q;

	// Acceptance decode
	bsfn_pkg::op_t               req_op;
	logic                        accept;
	logic                        in_store;
	logic                        hi_oor;
	logic [31:0]                 top;
	logic                        walk;
	logic                        imm_flag;
	logic [31:0]                 imm_found;
	logic                        imm_oor;
	bsfn_pkg::word_idx_t         imm_end_w;
	logic [5:0]                  imm_top_lo;

	// Evaluation of the word just read
	bsfn_pkg::word_t             cur_word;
	bsfn_pkg::word_t             bit_sel;
	bsfn_pkg::word_t             rng_mask;
	bsfn_pkg::word_t             find_word;
	logic [5:0]                  lb;
	logic [5:0]                  hb;
	logic                        wr_en;
	bsfn_pkg::word_t             wr_word;
	logic                        eval_more;
	logic                        eval_flag;
	logic [31:0]                 eval_found;
	logic                        slot_free;

	assign req_op    = bsfn_pkg::op_t'(req.operation);
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !rsp_vld_q || rsp.ready;

	// Decode a new word: either start a walk of the store or resolve at once
	always_comb begin
		in_store   = ({1'b0, req.element} < bsfn_pkg::STORE_BITS);
		hi_oor     = ({1'b0, req.range_end} >= bsfn_pkg::STORE_BITS);
		top        = hi_oor ? 32'(bsfn_pkg::STORE_BITS - 33'd1) : req.range_end;
		walk       = 1'b0;
		imm_flag   = 1'b0;
		imm_found  = '0;
		imm_oor    = 1'b0;
		imm_end_w  = req.element[6 +: bsfn_pkg::WORD_AW];
		imm_top_lo = req.element[5:0];
		case (req_op)
			bsfn_pkg::OP_SET, bsfn_pkg::OP_CLEAR: begin
				walk    = in_store;
				imm_oor = !in_store;
			end
			bsfn_pkg::OP_TEST: begin
				walk     = in_store;
				imm_flag = default_q;
			end
			bsfn_pkg::OP_FIND_NEXT: begin
				walk      = in_store;
				imm_end_w = bsfn_pkg::LAST_WORD;
				imm_flag  = default_q;
				imm_found = default_q ? req.element : 32'd0;
			end
			bsfn_pkg::OP_SET_RANGE: begin
				if (req.element <= req.range_end) begin
					walk    = in_store;
					imm_oor = hi_oor;
				end
				imm_end_w  = top[6 +: bsfn_pkg::WORD_AW];
				imm_top_lo = top[5:0];
			end
			default: begin
			end
		endcase
	end

	// Modify the word read: logical value, masks, write back and search
	always_comb begin
		cur_word   = rd_vld_s1 ? (rd_data_s1 ^ {bsfn_pkg::WORD_BITS{inv_q}})
			: {bsfn_pkg::WORD_BITS{default_q}};
		bit_sel    = bsfn_pkg::word_t'(1) << lo_q;
		lb         = (word_q == first_w_q) ? lo_q : 6'd0;
		hb         = (word_q == end_w_q) ? top_lo_q : 6'd63;
		rng_mask   = (bsfn_pkg::FULL_WORD >> (6'd63 - hb)) & (bsfn_pkg::FULL_WORD << lb);
		find_word  = cur_word & (bsfn_pkg::FULL_WORD << lb);
		wr_en      = 1'b0;
		wr_word    = cur_word;
		eval_more  = 1'b0;
		eval_flag  = res_flag_q;
		eval_found = res_found_q;
		case (op_q)
			bsfn_pkg::OP_SET: begin
				wr_en     = 1'b1;
				wr_word   = cur_word | bit_sel;
				eval_flag = (cur_word & bit_sel) == '0;
			end
			bsfn_pkg::OP_CLEAR: begin
				wr_en   = 1'b1;
				wr_word = cur_word & ~bit_sel;
			end
			bsfn_pkg::OP_TEST: begin
				eval_flag = (cur_word & bit_sel) != '0;
			end
			bsfn_pkg::OP_FIND_NEXT: begin
				if (find_word != '0) begin
					eval_flag  = 1'b1;
					eval_found = (32'(word_q) << 6) | 32'(bsfn_pkg::lowest_one(find_word));
				end else if (word_q == end_w_q) begin
					eval_flag  = default_q;
					eval_found = default_q ? 32'(bsfn_pkg::STORE_BITS) : 32'd0;
				end else begin
					eval_more = 1'b1;
				end
			end
			bsfn_pkg::OP_SET_RANGE: begin
				wr_en     = 1'b1;
				wr_word   = cur_word | rng_mask;
				eval_more = (word_q != end_w_q);
			end
			default: begin
			end
		endcase
	end

	// Sequencer, valid flops, default and invert state, response handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			default_q <= 1'b0;
			inv_q     <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			// response register fills from the done state, empties on acceptance
			if (state_q == ST_DONE && slot_free)
				rsp_vld_q <= 1'b1;
			else if (rsp.ready)
				rsp_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_op)
							bsfn_pkg::OP_CLEAR_ALL: begin
								valid_q   <= '0;
								default_q <= 1'b0;
							end
							bsfn_pkg::OP_SET_ALL: begin
								valid_q   <= '0;
								default_q <= 1'b1;
							end
							bsfn_pkg::OP_INVERT: begin
								inv_q     <= !inv_q;
								default_q <= !default_q;
							end
							default: begin
							end
						endcase
						state_q <= walk ? ST_READ : ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (wr_en)
						valid_q[word_q] <= 1'b1;
					state_q <= eval_more ? ST_READ : ST_DONE;
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Word store: one read or one write per cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL && wr_en)
			mem[word_q] <= wr_word ^ {bsfn_pkg::WORD_BITS{inv_q}};
		if (state_q == ST_READ) begin
			rd_data_s1 <= mem[word_q];
			rd_vld_s1  <= valid_q[word_q];
		end
	end

	// Operands, running result and response word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= req_op;
			lo_q        <= req.element[5:0];
			top_lo_q    <= imm_top_lo;
			word_q      <= req.element[6 +: bsfn_pkg::WORD_AW];
			first_w_q   <= req.element[6 +: bsfn_pkg::WORD_AW];
			end_w_q     <= imm_end_w;
			res_flag_q  <= walk ? 1'b0 : imm_flag;
			res_found_q <= walk ? 32'd0 : imm_found;
			res_oor_q   <= imm_oor;
		end
		if (state_q == ST_EVAL) begin
			res_flag_q  <= eval_flag;
			res_found_q <= eval_found;
			if (eval_more)
				word_q <= word_q + bsfn_pkg::word_idx_t'(1);
		end
		if (state_q == ST_DONE && slot_free) begin
			rsp_flag_q  <= res_flag_q;
			rsp_found_q <= res_found_q;
			rsp_oor_q   <= res_oor_q;
		end
	end

	assign rsp.valid         = rsp_vld_q;
	assign rsp.flag          = rsp_flag_q;
	assign rsp.found_element = rsp_found_q;
	assign rsp.out_of_range  = rsp_oor_q;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the bit set with find-next: a class mirrors the word store and
// the default bit, predicts every response word and checks it as it leaves the block.
// Depends on bsfn_pkg, bsfn_req_if, bsfn_rsp_if and bitset_with_find_next.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_WORDS = 1150;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned DRAIN_CYCLES = 200;
	localparam int unsigned WBITS        = bsfn_pkg::WORD_BITS;
	localparam int unsigned NWORDS       = bsfn_pkg::SET_WORDS;
	localparam logic [31:0] STORE_SIZE   = 32'(bsfn_pkg::STORE_BITS);

	typedef struct packed {
		logic        flag;
		logic [31:0] found;
		logic        oor;
	} set_result_t;

	// Mirror of the set: word store, default bit and the responses still owed
	class bitset_mirror;
		bsfn_pkg::word_t store [bsfn_pkg::SET_WORDS];
		logic        dflt;
		set_result_t owed [$];
		int unsigned errors;
		int unsigned words_seen;
		int unsigned find_hits;
		int unsigned oor_seen;

		function new();
			fill(1'b0);
			errors     = 0;
			words_seen = 0;
			find_hits  = 0;
			oor_seen   = 0;
		endfunction

		function void fill(logic v);
			foreach (store[i])
				store[i] = v ? bsfn_pkg::FULL_WORD : '0;
			dflt = v;
		endfunction

		function int unsigned first_member(bsfn_pkg::word_t v);
			int unsigned pos;
			pos = 0;
			for (int b = WBITS - 1; b >= 0; b--)
				if (v[b])
					pos = b;
			return pos;
		endfunction

		// Apply one request word to the mirror and queue the response it owes
		function void note_request(bsfn_pkg::op_t op, logic [31:0] e, logic [31:0] hi);
			set_result_t r;
			int unsigned w;
			int unsigned lb;
			int unsigned hb;
			logic [32:0] top;
			bsfn_pkg::word_t cur;
			logic        in_store;
			r = '0;
			in_store = ({1'b0, e} < bsfn_pkg::STORE_BITS);
			w  = e / WBITS;
			lb = e % WBITS;
			case (op)
			bsfn_pkg::OP_SET: begin
				if (!in_store) begin
					r.oor = 1'b1;
				end else if (!store[w][lb]) begin
					r.flag       = 1'b1;
					store[w][lb] = 1'b1;
				end
			end
			bsfn_pkg::OP_CLEAR: begin
				if (in_store)
					store[w][lb] = 1'b0;
				else
					r.oor = 1'b1;
			end
			bsfn_pkg::OP_TEST: begin
				r.flag = in_store ? store[w][lb] : dflt;
			end
			bsfn_pkg::OP_FIND_NEXT: begin
				// walk from the start word, masking bits below the start in the first one
				if (in_store) begin
					cur = store[w] & (bsfn_pkg::FULL_WORD << lb);
					while (!r.flag && w < NWORDS) begin
						if (cur != '0) begin
							r.flag  = 1'b1;
							r.found = 32'(w * WBITS + first_member(cur));
						end else begin
							w++;
							if (w < NWORDS)
								cur = store[w];
						end
					end
				end
				// nothing in the store: the default bit covers everything beyond it
				if (!r.flag && dflt) begin
					r.flag  = 1'b1;
					r.found = in_store ? STORE_SIZE : e;
				end
				if (r.flag)
					find_hits++;
			end
			bsfn_pkg::OP_SET_RANGE: begin
				if (e <= hi) begin
					top = {1'b0, hi};
					if (top >= bsfn_pkg::STORE_BITS) begin
						r.oor = 1'b1;
						top   = bsfn_pkg::STORE_BITS - 33'd1;
					end
					if (in_store) begin
						for (w = e / WBITS; w <= top / WBITS; w++) begin
							lb = (w == e / WBITS) ? e % WBITS : 0;
							hb = (w == top / WBITS) ? top % WBITS : WBITS - 1;
							store[w] |= (bsfn_pkg::FULL_WORD >> (WBITS - 1 - hb))
								& (bsfn_pkg::FULL_WORD << lb);
						end
					end
				end
			end
			bsfn_pkg::OP_CLEAR_ALL: fill(1'b0);
			bsfn_pkg::OP_SET_ALL:   fill(1'b1);
			default: begin
				foreach (store[i])
					store[i] = ~store[i];
				dflt = ~dflt;
			end
			endcase
			if (r.oor)
				oor_seen++;
			words_seen++;
			owed.push_back(r);
		endfunction

		// Compare a response word with the oldest one owed
		function void check_result(logic flag, logic [31:0] found, logic oor);
			set_result_t want;
			if (owed.size() == 0) begin
				$error("unexpected response word: flag=%0d found_element=%0d out_of_range=%0d",
					flag, found, oor);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (flag !== want.flag) begin
				$error("flag: expected %0d, got %0d", want.flag, flag);
				errors++;
			end
			if (found !== want.found) begin
				$error("found_element: expected %0d, got %0d", want.found, found);
				errors++;
			end
			if (oor !== want.oor) begin
				$error("out_of_range: expected %0d, got %0d", want.oor, oor);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	bit          steady;
	int unsigned cycles = 0;
	bitset_mirror mirror;

	bsfn_req_if req_ch ();
	bsfn_rsp_if rsp_ch ();

	bitset_with_find_next dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Response side back-pressure, switched off during the steady stretch
	always @(negedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(99) >= 28);
	end

	// Watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				mirror.check_result(rsp_ch.flag, rsp_ch.found_element, rsp_ch.out_of_range);
			if (req_ch.valid && req_ch.ready)
				mirror.note_request(bsfn_pkg::op_t'(req_ch.operation), req_ch.element,
					req_ch.range_end);
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$error("no progress after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Present one request word, with a random gap ahead of it; returns on a falling edge
	task automatic send_word(bsfn_pkg::op_t op, logic [31:0] e, logic [31:0] hi);
		while (!steady && $urandom_range(99) < 28) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.element   <= e;
		req_ch.range_end <= hi;
		do
			@(posedge clk);
		while (!req_ch.ready);
		@(negedge clk);
	endtask

	function automatic bsfn_pkg::op_t pick_op();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 24)
			return bsfn_pkg::OP_SET;
		if (r < 36)
			return bsfn_pkg::OP_CLEAR;
		if (r < 50)
			return bsfn_pkg::OP_TEST;
		if (r < 74)
			return bsfn_pkg::OP_FIND_NEXT;
		if (r < 86)
			return bsfn_pkg::OP_SET_RANGE;
		if (r < 91)
			return bsfn_pkg::OP_CLEAR_ALL;
		if (r < 94)
			return bsfn_pkg::OP_SET_ALL;
		return bsfn_pkg::OP_INVERT;
	endfunction

	// Mostly inside the store, with a dense low corner, the store edge and the top of the space
	function automatic logic [31:0] pick_element();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45)
			return $urandom_range(STORE_SIZE - 1, 0);
		if (r < 65)
			return $urandom_range(255, 0);
		if (r < 75)
			return STORE_SIZE - 8 + $urandom_range(15, 0);
		if (r < 85)
			return $urandom;
		if (r < 92)
			return 32'hFFFF_FFFF - $urandom_range(15, 0);
		return $urandom_range(NWORDS - 1, 0) * WBITS
			+ ($urandom_range(1) ? WBITS - 1 : 0);
	endfunction

	function automatic logic [31:0] pick_range_end(logic [31:0] e);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return e + $urandom_range(130, 0);
		if (r < 65)
			return e + $urandom_range(STORE_SIZE, 0);
		if (r < 80)
			return $urandom;
		if (r < 90)
			return e - $urandom_range(64, 1);
		return 32'hFFFF_FFFF - $urandom_range(3, 0);
	endfunction

	initial begin
		logic [31:0]   e;
		bsfn_pkg::op_t op;
		mirror           = new();
		steady           = 1'b0;
		arst_n           = 1'b0;
		req_ch.valid     = 1'b0;
		req_ch.operation = bsfn_pkg::OP_SET;
		req_ch.element   = '0;
		req_ch.range_end = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: single bits, the store edge, empty and clipped ranges, default bit
		send_word(bsfn_pkg::OP_SET,       32'd0,          $urandom);
		send_word(bsfn_pkg::OP_SET,       32'd0,          $urandom);
		send_word(bsfn_pkg::OP_TEST,      32'd0,          $urandom);
		send_word(bsfn_pkg::OP_SET,       STORE_SIZE - 1, $urandom);
		send_word(bsfn_pkg::OP_SET,       STORE_SIZE,     $urandom);
		send_word(bsfn_pkg::OP_CLEAR,     32'hFFFF_FFFF,  $urandom);
		send_word(bsfn_pkg::OP_TEST,      32'd5000,       $urandom);
		send_word(bsfn_pkg::OP_FIND_NEXT, 32'd1,          $urandom);
		send_word(bsfn_pkg::OP_FIND_NEXT, STORE_SIZE,     $urandom);
		send_word(bsfn_pkg::OP_SET_RANGE, 32'd10,         32'd9);
		send_word(bsfn_pkg::OP_SET_RANGE, 32'd100,        32'd200);
		send_word(bsfn_pkg::OP_SET_RANGE, 32'd4000,       32'hFFFF_FFFF);
		send_word(bsfn_pkg::OP_FIND_NEXT, 32'd201,        $urandom);
		send_word(bsfn_pkg::OP_CLEAR,     STORE_SIZE - 1, $urandom);
		send_word(bsfn_pkg::OP_TEST,      STORE_SIZE - 1, $urandom);
		send_word(bsfn_pkg::OP_INVERT,    $urandom,       $urandom);
		send_word(bsfn_pkg::OP_TEST,      32'hFFFF_FFFF,  $urandom);
		send_word(bsfn_pkg::OP_FIND_NEXT, STORE_SIZE,     $urandom);
		send_word(bsfn_pkg::OP_FIND_NEXT, 32'hFFFF_FFFF,  $urandom);
		send_word(bsfn_pkg::OP_CLEAR_ALL, $urandom,       $urandom);
		send_word(bsfn_pkg::OP_FIND_NEXT, 32'd0,          $urandom);
		send_word(bsfn_pkg::OP_SET_RANGE, 32'd0,          STORE_SIZE - 1);
		// store now full, default clear; invert leaves an empty store with default set
		send_word(bsfn_pkg::OP_INVERT,    $urandom,       $urandom);
		send_word(bsfn_pkg::OP_FIND_NEXT, 32'd5,          $urandom);
		send_word(bsfn_pkg::OP_SET_ALL,   $urandom,       $urandom);

		// Random words; a stretch in the middle runs with no gaps and no stalls
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			steady <= (n >= 450 && n < 650);
			op = pick_op();
			e  = pick_element();
			send_word(op, e, (op == bsfn_pkg::OP_SET_RANGE) ? pick_range_end(e) : $urandom);
		end
		req_ch.valid <= 1'b0;

		// Let every owed response arrive, then watch for strays
		while (mirror.owed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d request words over all eight operations, edge and beyond-store %s",
			mirror.words_seen, "elements.");
		$display("%0d find-next hits, %0d out-of-range responses, %0d mismatches.",
			mirror.find_hits, mirror.oor_seen, mirror.errors);
		if (mirror.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
